// ----- src/tsd_pkg.sv -----
// Shared constants for the triangle signed distance pipeline.
package tsd_pkg;

    localparam int H_BITS = 16;
    localparam int EDGE_LAT = H_BITS + 6;
    localparam int ADDR_WIDTH = 5;

    typedef enum logic [2:0] {
        REG_V0_X = 3'd0,
        REG_V0_Y = 3'd1,
        REG_V1_X = 3'd2,
        REG_V1_Y = 3'd3,
        REG_V2_X = 3'd4,
        REG_V2_Y = 3'd5
    } reg_idx_t;

endpackage

// ----- src/tsd_edge.sv -----
// Per-edge pipeline: projection, clamped parameter division, squared distance.
module tsd_edge
    import tsd_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [CW:0]      vx,
    input  logic signed [CW:0]      vy,
    input  logic signed [CW:0]      ex,
    input  logic signed [CW:0]      ey,
    input  logic [2*CW+1:0]         ee,
    output logic [2*CW+3:0]         d2,
    output logic signed [2*CW+2:0]  cr
);

    localparam int VW = CW + 1;
    localparam int PW = 2 * CW + 3;
    localparam int RW = 2 * CW + 3;
    localparam int HB = H_BITS;
    localparam int HW = HB + 1;
    localparam int QW = CW + 2;
    localparam int DW = 2 * CW + 4;
    localparam int MW = VW + HW + 1;
    localparam logic signed [MW-1:0] HALF = MW'(1) <<< (HB - 1);

    logic signed [PW-1:0] dt_reg;
    logic signed [PW-1:0] cr1_reg;
    logic signed [VW-1:0] vx1_reg, vy1_reg;

    logic [RW-1:0]        rem_reg [0:HB];
    logic [HB-1:0]        quo_reg [0:HB];
    logic                 one_reg [0:HB];
    logic signed [VW-1:0] vxp_reg [0:HB];
    logic signed [VW-1:0] vyp_reg [0:HB];
    logic signed [PW-1:0] crp_reg [0:HB];

    logic                 zero_c, one_c;
    logic [HW-1:0]        h;

    logic signed [MW-1:0] prx_reg, pry_reg;
    logic signed [VW-1:0] vxm_reg, vym_reg;
    logic signed [PW-1:0] crm_reg;
    logic signed [MW-1:0] rx, ry;
    logic signed [QW-1:0] qx_reg, qy_reg;
    logic signed [PW-1:0] crq_reg;
    logic [DW-1:0]        sx_reg, sy_reg;
    logic signed [PW-1:0] crs_reg;
    logic [DW-1:0]        d2_reg;
    logic signed [PW-1:0] cro_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dt_reg  <= PW'(vx) * PW'(ex) + PW'(vy) * PW'(ey);
            cr1_reg <= PW'(vx) * PW'(ey) - PW'(vy) * PW'(ex);
            vx1_reg <= vx;
            vy1_reg <= vy;
        end
    end

    assign zero_c = (ee == '0) || (dt_reg <= 0);
    assign one_c  = !zero_c && ($unsigned(dt_reg) >= RW'(ee));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= (zero_c || one_c) ? '0 : $unsigned(dt_reg);
            quo_reg[0] <= '0;
            one_reg[0] <= one_c;
            vxp_reg[0] <= vx1_reg;
            vyp_reg[0] <= vy1_reg;
            crp_reg[0] <= cr1_reg;
        end
    end

    for (genvar k = 0; k < HB; k++)
    begin : g_div
        logic [RW-1:0] sh;
        logic          ge;
        assign sh = {rem_reg[k][RW-2:0], 1'b0};
        assign ge = sh >= RW'(ee);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? sh - RW'(ee) : sh;
                quo_reg[k+1] <= {quo_reg[k][HB-2:0], ge};
                one_reg[k+1] <= one_reg[k];
                vxp_reg[k+1] <= vxp_reg[k];
                vyp_reg[k+1] <= vyp_reg[k];
                crp_reg[k+1] <= crp_reg[k];
            end
        end
    end

    assign h = one_reg[HB] ? (HW'(1) << HB) : {1'b0, quo_reg[HB]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_reg <= MW'(ex) * $signed({{(MW-HW){1'b0}}, h});
            pry_reg <= MW'(ey) * $signed({{(MW-HW){1'b0}}, h});
            vxm_reg <= vxp_reg[HB];
            vym_reg <= vyp_reg[HB];
            crm_reg <= crp_reg[HB];
        end
    end

    assign rx = (prx_reg + HALF) >>> HB;
    assign ry = (pry_reg + HALF) >>> HB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg  <= QW'(MW'(vxm_reg) - rx);
            qy_reg  <= QW'(MW'(vym_reg) - ry);
            crq_reg <= crm_reg;
            sx_reg  <= $unsigned(DW'(qx_reg) * DW'(qx_reg));
            sy_reg  <= $unsigned(DW'(qy_reg) * DW'(qy_reg));
            crs_reg <= crq_reg;
            d2_reg  <= sx_reg + sy_reg;
            cro_reg <= crs_reg;
        end
    end

    assign d2 = d2_reg;
    assign cr = cro_reg;

endmodule

// ----- src/tsd_sqrt.sv -----
// Pipelined rounded integer square root, one result bit per stage.
module tsd_sqrt #(
    parameter int DW = 36
) (
    input  logic              clk,
    input  logic              en,
    input  logic [DW-1:0]     d,
    input  logic              pos_in,
    input  logic              zero_in,
    output logic [DW/2:0]     root,
    output logic              pos_out,
    output logic              zero_out
);

    localparam int K = DW / 2;

    logic [DW-1:0] n_reg   [0:K];
    logic [DW-1:0] r_reg   [0:K];
    logic          pos_reg [0:K];
    logic          zero_reg[0:K];
    logic [K:0]    root_reg;
    logic          posr_reg, zeror_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= d;
            r_reg[0]    <= '0;
            pos_reg[0]  <= pos_in;
            zero_reg[0] <= zero_in;
        end
    end

    for (genvar k = 0; k < K; k++)
    begin : g_root
        localparam logic [DW-1:0] BITV = DW'(1) << (2 * (K - 1 - k));
        logic [DW-1:0] t;
        assign t = r_reg[k] + BITV;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_reg[k] >= t)
                begin
                    n_reg[k+1] <= n_reg[k] - t;
                    r_reg[k+1] <= (r_reg[k] >> 1) + BITV;
                end
                else
                begin
                    n_reg[k+1] <= n_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
                pos_reg[k+1]  <= pos_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg  <= r_reg[K][K:0] + (K+1)'(n_reg[K] > r_reg[K]);
            posr_reg  <= pos_reg[K];
            zeror_reg <= zero_reg[K];
        end
    end

    assign root     = root_reg;
    assign pos_out  = posr_reg;
    assign zero_out = zeror_reg;

endmodule

// ----- src/triangle_signed_distance_unit.sv -----
// Triangle signed distance unit: top level with register port and pipeline control.
// Takes one query point per cycle while not stalled and returns its signed distance to
// the triangle held in the vertex registers (negative inside). The pipeline holds the
// 16-step edge-parameter divider and the COORD_WIDTH + 2 step square-root pipeline; a
// stall at the output holds the whole pipeline. Vertex writes pass through the edge
// registers and then the edge length and winding registers before they take effect.
module triangle_signed_distance_unit
    import tsd_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_WIDTH-1:0]         paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH+1:0] distance
);

    localparam int CW  = COORD_WIDTH;
    localparam int VW  = CW + 1;
    localparam int PW  = 2 * CW + 3;
    localparam int EEW = 2 * CW + 2;
    localparam int DW  = 2 * CW + 4;
    localparam int K   = DW / 2;
    localparam int OW  = CW + 2;
    localparam int LAT = 1 + EDGE_LAT + K + 2 + 1;
    localparam logic signed [OW-1:0] HI = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] LO = {1'b1, {(OW-1){1'b0}}};

    logic signed [CW-1:0] vtx_reg [0:5];
    logic signed [VW-1:0] ex_reg [0:2];
    logic signed [VW-1:0] ey_reg [0:2];
    logic [EEW-1:0]       ee_reg [0:2];
    logic signed [PW-1:0] wind_reg;

    logic                 advance;
    logic [LAT-1:0]       vld_reg;
    logic signed [VW-1:0] vx_reg [0:2];
    logic signed [VW-1:0] vy_reg [0:2];
    logic [DW-1:0]        d2 [0:2];
    logic signed [PW-1:0] cr [0:2];
    logic signed [PW-1:0] ca [0:2];
    logic [DW-1:0]        dmin;
    logic signed [PW-1:0] cmin;
    logic [K:0]           root;
    logic                 sq_pos, sq_zero;
    logic signed [OW-1:0] dist_next, dist_reg;
    logic                 wr;
    reg_idx_t             widx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                vtx_reg[i] <= '0;
            end
        end
        else if (wr)
        begin
            unique case (widx)
                REG_V0_X: vtx_reg[0] <= pwdata[CW-1:0];
                REG_V0_Y: vtx_reg[1] <= pwdata[CW-1:0];
                REG_V1_X: vtx_reg[2] <= pwdata[CW-1:0];
                REG_V1_Y: vtx_reg[3] <= pwdata[CW-1:0];
                REG_V2_X: vtx_reg[4] <= pwdata[CW-1:0];
                REG_V2_Y: vtx_reg[5] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (widx)
            REG_V0_X: prdata = 32'($unsigned(vtx_reg[0]));
            REG_V0_Y: prdata = 32'($unsigned(vtx_reg[1]));
            REG_V1_X: prdata = 32'($unsigned(vtx_reg[2]));
            REG_V1_Y: prdata = 32'($unsigned(vtx_reg[3]));
            REG_V2_X: prdata = 32'($unsigned(vtx_reg[4]));
            REG_V2_Y: prdata = 32'($unsigned(vtx_reg[5]));
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ex_reg[i] <= '0;
                ey_reg[i] <= '0;
                ee_reg[i] <= '0;
            end
            wind_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                ex_reg[i] <= VW'(vtx_reg[(2*i+2)%6]) - VW'(vtx_reg[2*i]);
                ey_reg[i] <= VW'(vtx_reg[(2*i+3)%6]) - VW'(vtx_reg[2*i+1]);
                ee_reg[i] <= $unsigned(EEW'(ex_reg[i]) * EEW'(ex_reg[i])
                                     + EEW'(ey_reg[i]) * EEW'(ey_reg[i]));
            end
            wind_reg <= PW'(ex_reg[0]) * PW'(ey_reg[2]) - PW'(ey_reg[0]) * PW'(ex_reg[2]);
        end
    end

    assign advance   = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= VW'(point_x) - VW'(vtx_reg[2*i]);
                vy_reg[i] <= VW'(point_y) - VW'(vtx_reg[2*i+1]);
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_edge
        tsd_edge #(
            .CW (CW)
        ) u_edge (
            .clk (clk),
            .en  (advance),
            .vx  (vx_reg[g]),
            .vy  (vy_reg[g]),
            .ex  (ex_reg[g]),
            .ey  (ey_reg[g]),
            .ee  (ee_reg[g]),
            .d2  (d2[g]),
            .cr  (cr[g])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (wind_reg < 0)
            begin
                ca[i] = -cr[i];
            end
            else if (wind_reg == 0)
            begin
                ca[i] = '0;
            end
            else
            begin
                ca[i] = cr[i];
            end
        end
        dmin = (d2[0] < d2[1]) ? d2[0] : d2[1];
        if (d2[2] < dmin)
        begin
            dmin = d2[2];
        end
        cmin = (ca[0] < ca[1]) ? ca[0] : ca[1];
        if (ca[2] < cmin)
        begin
            cmin = ca[2];
        end
    end

    tsd_sqrt #(
        .DW (DW)
    ) u_sqrt (
        .clk      (clk),
        .en       (advance),
        .d        (dmin),
        .pos_in   (cmin > 0),
        .zero_in  (cmin == 0),
        .root     (root),
        .pos_out  (sq_pos),
        .zero_out (sq_zero)
    );

    always_comb
    begin
        if (sq_zero)
        begin
            dist_next = '0;
        end
        else if (sq_pos)
        begin
            dist_next = (root > (K+1)'(1) << (OW - 1)) ? LO : -$signed(root[OW-1:0]);
        end
        else
        begin
            dist_next = (root > (K+1)'(HI)) ? HI : $signed(root[OW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dist_reg <= dist_next;
        end
    end

    assign distance = dist_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld_reg) && $stable(dist_reg))
        else $error("pipeline moved during output stall");

    a_zero_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && sq_zero) |=> (dist_reg == '0))
        else $error("zero sign did not give zero distance");

    a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted transaction lost its valid bit");

endmodule

// ----- dv/tb_triangle_signed_distance_unit.sv -----
// Self-checking testbench for the triangle signed distance unit.
`timescale 1ns / 1ps

class distance_scoreboard;
    longint vertex[8];
    logic signed [17:0] pending[$];
    int errors;

    function new();
        foreach (vertex[i]) vertex[i] = 0;
        errors = 0;
    endfunction

    function void set_vertex(int idx, logic signed [15:0] value);
        if (idx < 6) vertex[idx] = value;
    endfunction

    function void edge_term(input longint vx, input longint vy, input longint ex,
                            input longint ey, output longint d2, output longint cr);
        longint ee, dt, h, qx, qy;
        ee = ex * ex + ey * ey;
        dt = vx * ex + vy * ey;
        if (ee == 0 || dt <= 0) h = 0;
        else if (dt >= ee) h = 64'sd65536;
        else h = (dt * 64'sd65536) / ee;
        qx = vx - ((ex * h + 64'sd32768) >>> 16);
        qy = vy - ((ey * h + 64'sd32768) >>> 16);
        d2 = qx * qx + qy * qy;
        cr = vx * ey - vy * ex;
    endfunction

    function logic signed [17:0] distance_of(longint px, longint py);
        longint e0x, e0y, e1x, e1y, e2x, e2y, wind, dmin, cmin, r, t;
        longint d[3];
        longint c[3];
        e0x = vertex[2] - vertex[0]; e0y = vertex[3] - vertex[1];
        e1x = vertex[4] - vertex[2]; e1y = vertex[5] - vertex[3];
        e2x = vertex[0] - vertex[4]; e2y = vertex[1] - vertex[5];
        wind = e0x * e2y - e0y * e2x;
        edge_term(px - vertex[0], py - vertex[1], e0x, e0y, d[0], c[0]);
        edge_term(px - vertex[2], py - vertex[3], e1x, e1y, d[1], c[1]);
        edge_term(px - vertex[4], py - vertex[5], e2x, e2y, d[2], c[2]);
        for (int i = 0; i < 3; i++)
        begin
            if (wind < 0) c[i] = -c[i];
            else if (wind == 0) c[i] = 0;
        end
        dmin = d[0]; cmin = c[0];
        for (int i = 1; i < 3; i++)
        begin
            if (d[i] < dmin) dmin = d[i];
            if (c[i] < cmin) cmin = c[i];
        end
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (64'sd1 << b);
            if (t * t <= dmin) r = t;
        end
        if (dmin - r * r > r) r = r + 1;
        if (cmin == 0) return 18'sd0;
        if (cmin > 0) return (r > 131072) ? 18'sh20000 : 18'(-r);
        return (r > 131071) ? 18'sd131071 : 18'(r);
    endfunction

    function void note_point(logic signed [15:0] px, logic signed [15:0] py);
        pending.push_back(distance_of(px, py));
    endfunction

    function void check_distance(logic signed [17:0] actual);
        logic signed [17:0] want;
        if (pending.size() == 0)
        begin
            $error("distance: unexpected result, actual %0d", actual);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (want !== actual)
        begin
            $error("distance: expected %0d, actual %0d", want, actual);
            errors++;
        end
    endfunction
endclass

module tb_triangle_signed_distance_unit
    import tsd_pkg::*;
();

    localparam int LATENCY = 44;
    localparam longint CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] point_x, point_y;
    logic signed [17:0] distance;

    distance_scoreboard board;
    bit quiet;
    longint cycles;

    triangle_signed_distance_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_ready(out_ready), .distance(distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("triangle_signed_distance_unit verification failed");
            $finish;
        end
        if (rst_n && in_valid && in_ready) board.note_point(point_x, point_y);
        if (rst_n && out_valid && out_ready) board.check_distance(distance);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet)
                out_ready <= 1'b1;
            else if (hold > 0)
                hold--;
            else
            begin
                out_ready <= ($urandom_range(0, 2) != 0);
                hold = pick_gap();
            end
        end
    end

    task automatic write_reg(int idx, logic signed [15:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_WIDTH'(4 * idx); pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_vertex(idx, value);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 6) @(posedge clk);
    endtask

    task automatic set_triangle(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] bx, logic signed [15:0] by,
                                logic signed [15:0] cx, logic signed [15:0] cy);
        drain();
        write_reg(REG_V0_X, ax); write_reg(REG_V0_Y, ay);
        write_reg(REG_V1_X, bx); write_reg(REG_V1_Y, by);
        write_reg(REG_V2_X, cx); write_reg(REG_V2_Y, cy);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_point(logic signed [15:0] px, logic signed [15:0] py);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1; point_x <= px; point_y <= py;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] near(longint center, longint span);
        longint v;
        v = center + $signed($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    initial
    begin
        longint span;
        logic signed [15:0] t[6];
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; in_valid = 1'b0; point_x = '0; point_y = '0;
        board = new();
        quiet = 1'b0;
        @(posedge rst_n);

        send_point(16'sd100, -16'sd100);
        send_point(-16'sd32768, 16'sd32767);
        stop_sending();

        set_triangle(0, 0, 1024, 0, 0, 1024);
        send_point(256, 256);
        send_point(0, 0);
        send_point(1024, 0);
        send_point(512, 512);
        send_point(512, 0);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd32767, 16'sd32767);
        send_point(16'sd32767, -16'sd32768);
        send_point(-16'sd32768, 16'sd32767);
        stop_sending();

        set_triangle(0, 0, 0, 1024, 1024, 0);
        send_point(256, 256);
        send_point(2000, 2000);
        stop_sending();

        set_triangle(300, 300, 300, 300, 900, -50);
        send_point(600, 100);
        send_point(-700, 40);
        stop_sending();

        set_triangle(0, 0, 500, 500, 1000, 1000);
        send_point(250, 250);
        send_point(0, 900);
        stop_sending();

        set_triangle(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
                     -16'sd32768, 16'sd32767);
        send_point(0, 0);
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        stop_sending();

        drain();
        write_reg(6, 16'sd1234);
        write_reg(7, -16'sd1);
        repeat (4) @(posedge clk);
        send_point(-16'sd40, 16'sd20);
        stop_sending();

        for (int phase = 0; phase < 14; phase++)
        begin
            quiet = (phase % 5 == 2);
            case ($urandom_range(0, 3))
                0: span = 64;
                1: span = 2048;
                2: span = 12000;
                default: span = 32767;
            endcase
            foreach (t[i]) t[i] = near(0, span);
            if (phase == 4) t[2] = t[0];
            if (phase == 7)
            begin
                t[2] = t[0]; t[3] = t[1]; t[4] = t[0]; t[5] = t[1];
            end
            if (phase == 9)
            begin
                t[4] = t[2]; t[5] = t[3];
            end
            set_triangle(t[0], t[1], t[2], t[3], t[4], t[5]);
            for (int n = 0; n < 30; n++)
            begin
                if (n == 15 && phase == 6)
                begin
                    stop_sending();
                    while (board.pending.size() != 0) @(posedge clk);
                end
                if ($urandom_range(0, 3) == 0)
                    send_point(16'($urandom), 16'($urandom));
                else
                    send_point(near(t[2 * (n % 3)], span + 16),
                               near(t[2 * (n % 3) + 1], span + 16));
            end
            stop_sending();
        end
        quiet = 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("triangle_signed_distance_unit verification clean");
        else
            $display("triangle_signed_distance_unit verification failed");
        $finish;
    end
endmodule

// ----- files.f -----
src/tsd_pkg.sv
src/tsd_edge.sv
src/tsd_sqrt.sv
src/triangle_signed_distance_unit.sv
dv/tb_triangle_signed_distance_unit.sv
